// ===== sv/blink_envelope_timer_defines.svh =====
// ----------------------------------------------------------------------------
// blink envelope timer assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef BLINK_ENVELOPE_TIMER_DEFINES_SVH
`define BLINK_ENVELOPE_TIMER_DEFINES_SVH

// same-cycle implication
`define BET_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bet_pkg.sv =====
// ----------------------------------------------------------------------------
// bet_pkg
// types, codes and constants shared by the blink envelope timer files
// ----------------------------------------------------------------------------
package bet_pkg;

   // field widths
   localparam int MS_W      = 16;
   localparam int WAIT_W    = 17;
   localparam int OPEN_W    = 17;
   localparam int CHANCE_W  = 10;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;

   // openness scale
   localparam int FRAC_W = 16;
   localparam logic [OPEN_W-1:0] FULL_OPEN = OPEN_W'(1 << FRAC_W);

   // serial divider sizing: dividend is a ms difference shifted up by FRAC_W
   localparam int DIV_STEPS = MS_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // default tick length
   localparam int TICK_MS_DEF = 10;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_BLINK = 2'd1;
   localparam logic [OP_W-1:0] OP_BEGIN = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_LENGTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OPENNESS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CHANCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_GAP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MIN       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MAX       = 3'd6;

   // register reset values
   localparam logic [MS_W-1:0]     BLINK_LENGTH_RST  = 16'd150;
   localparam logic [MS_W-1:0]     CLOSE_LENGTH_RST  = 16'd45;
   localparam logic [OPEN_W-1:0]   MIN_OPENNESS_RST  = 17'd3277;
   localparam logic [CHANCE_W-1:0] DOUBLE_CHANCE_RST = 10'd150;
   localparam logic [MS_W-1:0]     DOUBLE_GAP_RST    = 16'd250;
   localparam logic [MS_W-1:0]     GAP_MIN_RST       = 16'd2000;
   localparam logic [MS_W-1:0]     GAP_MAX_RST       = 16'd6000;

   // divider request and status
   typedef struct packed {
      logic            start;
      logic [MS_W-1:0] numer;
      logic [MS_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [OPEN_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/blink_envelope_timer.sv =====
// ----------------------------------------------------------------------------
// blink_envelope_timer
// eyelid openness envelope on a randomized wait timer
// ----------------------------------------------------------------------------
// Each request beat is one control tick (op 0), an immediate blink (op 1) or a
// begin that only schedules the first wait (op 2); every beat yields exactly
// one response beat with the lid openness (Q1.16, 65536 fully open) and the
// blink flag. A tick inside the closing or opening ramp runs the bit-serial
// divider, one quotient bit per cycle over 32 dividend bits, before its
// response is registered; every other beat goes straight from idle to the
// send state. While an earlier response is stalled, a finished beat waits in
// the send state until the output register is free. One beat is worked at a
// time; a finished response sits in the output register so the next request
// beat can be taken while it waits. Registers are to be written through the
// csr port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "blink_envelope_timer_defines.svh"

module blink_envelope_timer
   import bet_pkg::*;
#(
   parameter int TICK_MS = TICK_MS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_op,
   input  logic [CHANCE_W-1:0]  req_chance_draw,
   input  logic [MS_W-1:0]      req_gap_offset_draw,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OPEN_W-1:0]    rsp_openness,
   output logic                 rsp_blink_active,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam logic [WAIT_W-1:0] TICK = WAIT_W'(TICK_MS);
   localparam logic [MS_W-1:0]   PHASE_MAX = '1;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]          state_ff, state_in;

   // configuration
   logic [MS_W-1:0]     blink_len_ff, blink_len_in;
   logic [MS_W-1:0]     close_len_ff, close_len_in;
   logic [OPEN_W-1:0]   min_open_ff, min_open_in;
   logic [CHANCE_W-1:0] dbl_chance_ff, dbl_chance_in;
   logic [MS_W-1:0]     dbl_gap_ff, dbl_gap_in;
   logic [MS_W-1:0]     gap_min_ff, gap_min_in;
   logic [MS_W-1:0]     gap_max_ff, gap_max_in;

   // envelope state
   logic                env_active_ff, env_active_in;
   logic [MS_W-1:0]     phase_ff, phase_in;
   logic [WAIT_W-1:0]   wait_left_ff, wait_left_in;
   logic                dbl_pending_ff, dbl_pending_in;
   logic [OPEN_W-1:0]   open_now_ff, open_now_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OPEN_W-1:0]   rsp_open_ff, rsp_open_in;
   logic                rsp_active_ff, rsp_active_in;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic [OPEN_W-1:0]   floor_v;
   logic [WAIT_W-1:0]   wait_dec;
   logic [MS_W:0]       phase_sum;
   logic [MS_W-1:0]     phase_inc;
   logic                sched_double;
   logic [MS_W-1:0]     span;
   logic [MS_W-1:0]     offset_cl;
   logic [WAIT_W-1:0]   sched_wait;

   bet_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // helpers: floor clamp, countdown, phase step, next wait
   always_comb begin
      floor_v   = (min_open_ff > FULL_OPEN) ? FULL_OPEN : min_open_ff;
      wait_dec  = (wait_left_ff > TICK) ? (wait_left_ff - TICK) : '0;
      phase_sum = {1'b0, phase_ff} + TICK[MS_W:0];
      phase_inc = phase_sum[MS_W] ? PHASE_MAX : phase_sum[MS_W-1:0];
      sched_double = !dbl_pending_ff && (req_chance_draw < dbl_chance_ff);
      span      = gap_max_ff - gap_min_ff;
      offset_cl = (req_gap_offset_draw >= span) ? (span - 1'b1) : req_gap_offset_draw;
      if (sched_double) begin
         sched_wait = {1'b0, dbl_gap_ff};
      end else if (gap_max_ff <= gap_min_ff) begin
         sched_wait = {1'b0, gap_min_ff};
      end else begin
         sched_wait = {1'b0, gap_min_ff} + {1'b0, offset_cl};
      end
   end

   // sequencer and state update
   always_comb begin
      state_in       = state_ff;
      blink_len_in   = blink_len_ff;
      close_len_in   = close_len_ff;
      min_open_in    = min_open_ff;
      dbl_chance_in  = dbl_chance_ff;
      dbl_gap_in     = dbl_gap_ff;
      gap_min_in     = gap_min_ff;
      gap_max_in     = gap_max_ff;
      env_active_in  = env_active_ff;
      phase_in       = phase_ff;
      wait_left_in   = wait_left_ff;
      dbl_pending_in = dbl_pending_ff;
      open_now_in    = open_now_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_open_in    = rsp_open_ff;
      rsp_active_in  = rsp_active_ff;
      div_req.start  = 1'b0;
      div_req.numer  = close_len_ff - phase_ff;
      div_req.denom  = close_len_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_BLINK_LENGTH:  blink_len_in  = csr_wdata[MS_W-1:0];
            CSR_CLOSE_LENGTH:  close_len_in  = csr_wdata[MS_W-1:0];
            CSR_MIN_OPENNESS:  min_open_in   = csr_wdata[OPEN_W-1:0];
            CSR_DOUBLE_CHANCE: dbl_chance_in = csr_wdata[CHANCE_W-1:0];
            CSR_DOUBLE_GAP:    dbl_gap_in    = csr_wdata[MS_W-1:0];
            CSR_GAP_MIN:       gap_min_in    = csr_wdata[MS_W-1:0];
            CSR_GAP_MAX:       gap_max_in    = csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end

      // response beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEND;
               case (req_op)
                  OP_TICK: begin
                     if (!env_active_ff) begin
                        wait_left_in = wait_dec;
                        if (wait_dec == '0) begin
                           env_active_in = 1'b1;
                           phase_in      = '0;
                        end
                        open_now_in = FULL_OPEN;
                     end else if (phase_ff >= blink_len_ff) begin
                        open_now_in    = FULL_OPEN;
                        env_active_in  = 1'b0;
                        phase_in       = '0;
                        dbl_pending_in = sched_double;
                        wait_left_in   = sched_wait;
                     end else if (phase_ff < close_len_ff) begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end else if (blink_len_ff > close_len_ff) begin
                        div_req.start = 1'b1;
                        div_req.numer = phase_ff - close_len_ff;
                        div_req.denom = blink_len_ff - close_len_ff;
                        state_in      = ST_DIV;
                     end else begin
                        open_now_in = floor_v;
                        phase_in    = phase_inc;
                     end
                  end
                  OP_BLINK: begin
                     env_active_in = 1'b1;
                     phase_in      = '0;
                  end
                  OP_BEGIN: begin
                     dbl_pending_in = sched_double;
                     wait_left_in   = sched_wait;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               open_now_in = (div_rsp.quotient < floor_v) ? floor_v : div_rsp.quotient;
               phase_in    = phase_inc;
               state_in    = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_open_in   = open_now_ff;
               rsp_active_in = env_active_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         blink_len_ff   <= BLINK_LENGTH_RST;
         close_len_ff   <= CLOSE_LENGTH_RST;
         min_open_ff    <= MIN_OPENNESS_RST;
         dbl_chance_ff  <= DOUBLE_CHANCE_RST;
         dbl_gap_ff     <= DOUBLE_GAP_RST;
         gap_min_ff     <= GAP_MIN_RST;
         gap_max_ff     <= GAP_MAX_RST;
         env_active_ff  <= 1'b0;
         phase_ff       <= '0;
         wait_left_ff   <= '0;
         dbl_pending_ff <= 1'b0;
         open_now_ff    <= FULL_OPEN;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         blink_len_ff   <= blink_len_in;
         close_len_ff   <= close_len_in;
         min_open_ff    <= min_open_in;
         dbl_chance_ff  <= dbl_chance_in;
         dbl_gap_ff     <= dbl_gap_in;
         gap_min_ff     <= gap_min_in;
         gap_max_ff     <= gap_max_in;
         env_active_ff  <= env_active_in;
         phase_ff       <= phase_in;
         wait_left_ff   <= wait_left_in;
         dbl_pending_ff <= dbl_pending_in;
         open_now_ff    <= open_now_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_open_ff   <= rsp_open_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_openness     = rsp_open_ff;
   assign rsp_blink_active = rsp_active_ff;

   // checks
   `BET_ASSERT_NOW(a_open_range, rsp_valid, rsp_openness <= FULL_OPEN, "openness above full")
   `BET_ASSERT_NOW(a_div_in_state, div_rsp.done, state_ff == ST_DIV, "divider done outside divide")
   `BET_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "second beat taken")
   `BET_ASSERT_NOW(a_idle_phase, !env_active_ff, phase_ff == '0, "phase nonzero while waiting")

endmodule

// ===== sv/bet_div.sv =====
// ----------------------------------------------------------------------------
// bet_div
// bit-serial restoring divider: (numer << 16) / denom, one quotient bit a cycle
// ----------------------------------------------------------------------------
module bet_div
   import bet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_STEPS-1:0]  dvd_ff, dvd_in;
   logic [MS_W-1:0]       rem_ff, rem_in;
   logic [MS_W-1:0]       den_ff, den_in;
   logic [OPEN_W-1:0]     quo_ff, quo_in;

   logic [MS_W:0]         rem_sh;
   logic [MS_W:0]         rem_sub;
   logic                  fits;

   // one restoring step
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_STEPS-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = {div_req.numer, {FRAC_W{1'b0}}};
         rem_in  = '0;
         den_in  = div_req.denom;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_STEPS-2:0], 1'b0};
         rem_in = fits ? rem_sub[MS_W-1:0] : rem_sh[MS_W-1:0];
         quo_in = {quo_ff[OPEN_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== bench/blink_envelope_timer_test.sv =====
// ----------------------------------------------------------------------------
// blink_envelope_timer_test
// self-checking bench: a directed opening table, then randomized tick, blink
// and begin beats over several register settings, every response beat checked
// against the table's expected value or an in-bench eyelid predictor, with
// bursty requests and stalled responses
// ----------------------------------------------------------------------------
module blink_envelope_timer_test;
   import bet_pkg::*;

   localparam int unsigned TICK          = TICK_MS_DEF;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          LONG_HOLD     = 400;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          RANDOM_SETS   = 5;

   // op code the block leaves unused
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OPEN_W-1:0] openness;
      logic              blink_active;
   } lid_beat_type;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [CHANCE_W-1:0] chance;
      logic [MS_W-1:0]     offset;
      int                  reps;
      bit                  typed;
      lid_beat_type        want;
   } stim_row_type;

   typedef struct {
      logic [CSR_DAT_W-1:0] blink;
      logic [CSR_DAT_W-1:0] close;
      logic [CSR_DAT_W-1:0] min_open;
      logic [CSR_DAT_W-1:0] chance;
      logic [CSR_DAT_W-1:0] dgap;
      logic [CSR_DAT_W-1:0] gmin;
      logic [CSR_DAT_W-1:0] gmax;
      int                   beats;
   } lid_setting_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op;
   logic [CHANCE_W-1:0]  req_chance_draw;
   logic [MS_W-1:0]      req_gap_offset_draw;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [OPEN_W-1:0]    rsp_openness;
   logic                 rsp_blink_active;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   blink_envelope_timer #(
      .TICK_MS (TICK)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_chance_draw     (req_chance_draw),
      .req_gap_offset_draw (req_gap_offset_draw),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_openness        (rsp_openness),
      .rsp_blink_active    (rsp_blink_active),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // eyelid predictor: register copies
   logic [MS_W-1:0]     cfg_blink;
   logic [MS_W-1:0]     cfg_close;
   logic [OPEN_W-1:0]   cfg_min_open;
   logic [CHANCE_W-1:0] cfg_chance;
   logic [MS_W-1:0]     cfg_dgap;
   logic [MS_W-1:0]     cfg_gmin;
   logic [MS_W-1:0]     cfg_gmax;

   // eyelid predictor: lid state
   bit                  env_on;
   int unsigned         phase;
   int unsigned         wait_ms;
   bit                  dbl_pending;
   logic [OPEN_W-1:0]   lid_open;

   lid_beat_type lid_due_q [$];
   int        fail_count  = 0;
   int        cycle_count = 0;
   int        burst_left  = 0;
   bit        hold_req    = 1'b0;

   // opening table, run under the reset register values
   stim_row_type opening_rows [0:9] = '{
      // wait is zero out of reset, so the first tick starts a blink
      '{OP_TICK,   10'd999,  16'h0000, 1,  1'b1, '{FULL_OPEN, 1'b1}},
      // phase zero of the ramp is still fully open
      '{OP_TICK,   10'd0,    16'h0000, 1,  1'b1, '{FULL_OPEN, 1'b1}},
      '{OP_TICK,   10'd0,    16'h0000, 4,  1'b0, '{'0, 1'b0}},
      // restart mid-blink, openness holds
      '{OP_BLINK,  10'd1023, 16'hAAAA, 1,  1'b0, '{'0, 1'b0}},
      '{OP_TICK,   10'd0,    16'h0000, 1,  1'b1, '{FULL_OPEN, 1'b1}},
      // begin queues a double, second begin clears it with a clamped offset
      '{OP_BEGIN,  10'd0,    16'h0000, 1,  1'b1, '{FULL_OPEN, 1'b1}},
      '{OP_BEGIN,  10'd0,    16'hFFFF, 1,  1'b1, '{FULL_OPEN, 1'b1}},
      '{OP_UNUSED, 10'h2AA,  16'h5555, 1,  1'b1, '{FULL_OPEN, 1'b1}},
      // rest of the close, the open ramp and the floor
      '{OP_TICK,   10'd0,    16'h0000, 14, 1'b0, '{'0, 1'b0}},
      // envelope ends and reschedules
      '{OP_TICK,   10'h155,  16'h5555, 1,  1'b1, '{FULL_OPEN, 1'b0}}
   };

   // fixed settings: typical, the low extremes, zero blink with floor above full,
   // close past blink with an empty span, the high extremes
   lid_setting_type fixed_settings [0:4] = '{
      '{17'd60,    17'd20,    17'd3277,   17'd300,  17'd30,    17'd20,    17'd120,   150},
      '{17'd1,     17'd0,     17'd0,      17'd1000, 17'd0,     17'd0,     17'd0,     80},
      '{17'd0,     17'd0,     17'd131071, 17'd1023, 17'd65535, 17'd65535, 17'd65535, 30},
      '{17'd40,    17'd60,    17'd100,    17'd0,    17'd10,    17'd30,    17'd10,    120},
      '{17'd65535, 17'd65534, 17'd65536,  17'd500,  17'd65535, 17'd0,     17'd65535, 40}
   };

   // next wait: short double gap or clamped ordinary gap
   function automatic void schedule_next_wait(input logic [CHANCE_W-1:0] chance,
                                              input logic [MS_W-1:0] offset);
      int unsigned span;
      int unsigned off;
      if (!dbl_pending && chance < cfg_chance) begin
         dbl_pending = 1'b1;
         wait_ms     = 32'(cfg_dgap);
      end else begin
         dbl_pending = 1'b0;
         if (cfg_gmax <= cfg_gmin) begin
            wait_ms = 32'(cfg_gmin);
         end else begin
            span = int'(cfg_gmax) - int'(cfg_gmin);
            off  = 32'(offset);
            if (off >= span) off = span - 1;
            wait_ms = int'(cfg_gmin) + off;
         end
      end
   endfunction

   // linear close then open, floored
   function automatic logic [OPEN_W-1:0] ramp_openness();
      longint unsigned   raw;
      logic [OPEN_W-1:0] floor_v;
      floor_v = (cfg_min_open > FULL_OPEN) ? FULL_OPEN : cfg_min_open;
      if (phase < cfg_close) begin
         raw = (longint'(int'(cfg_close) - phase) << FRAC_W) / cfg_close;
      end else if (cfg_blink > cfg_close) begin
         raw = (longint'(phase - int'(cfg_close)) << FRAC_W) /
               longint'(int'(cfg_blink) - int'(cfg_close));
      end else begin
         raw = 0;
      end
      if (raw > FULL_OPEN) raw = FULL_OPEN;
      return (raw < floor_v) ? floor_v : OPEN_W'(raw);
   endfunction

   // one accepted request beat through the eyelid predictor
   function automatic lid_beat_type step_eyelid(input logic [OP_W-1:0] op,
                                                input logic [CHANCE_W-1:0] chance,
                                                input logic [MS_W-1:0] offset);
      lid_beat_type beat;
      case (op)
         OP_TICK: begin
            if (!env_on) begin
               wait_ms = (wait_ms > TICK) ? wait_ms - TICK : 0;
               if (wait_ms == 0) begin
                  env_on = 1'b1;
                  phase  = 0;
               end
               lid_open = FULL_OPEN;
            end else if (phase >= cfg_blink) begin
               lid_open = FULL_OPEN;
               env_on   = 1'b0;
               phase    = 0;
               schedule_next_wait(chance, offset);
            end else begin
               lid_open = ramp_openness();
               phase    = (phase + TICK > 65535) ? 65535 : phase + TICK;
            end
         end
         OP_BLINK: begin
            env_on = 1'b1;
            phase  = 0;
         end
         OP_BEGIN: schedule_next_wait(chance, offset);
         default: ;
      endcase
      beat.openness     = lid_open;
      beat.blink_active = env_on;
      return beat;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("blink_envelope_timer verification failed");
         $finish;
      end
   end

   // response side stall pattern, with one long hold on request
   initial begin : rsp_backpressure
      int             seg_left;
      stall_mode_type mode;
      seg_left  = 0;
      mode      = STALL_NONE;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(5, 60);
               mode     = stall_mode_type'($urandom_range(0, 2));
            end
            seg_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:     rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   // response beat check
   always @(posedge clock) begin : lid_check
      lid_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (lid_due_q.size() == 0) begin
            $error("unexpected response beat: openness %0d blink_active %0b",
                   rsp_openness, rsp_blink_active);
            fail_count++;
         end else begin
            want = lid_due_q.pop_front();
            if (rsp_openness !== want.openness) begin
               $error("rsp_openness: expected %0d, actual %0d",
                      want.openness, rsp_openness);
               fail_count++;
            end
            if (rsp_blink_active !== want.blink_active) begin
               $error("rsp_blink_active: expected %0b, actual %0b",
                      want.blink_active, rsp_blink_active);
               fail_count++;
            end
         end
      end
   end

   // random bursts with gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // offer one request beat, predict it once taken
   task automatic offer_beat(input logic [OP_W-1:0] op, input logic [CHANCE_W-1:0] chance,
                             input logic [MS_W-1:0] offset, input bit typed,
                             input lid_beat_type typed_want);
      lid_beat_type want;
      req_valid           <= 1'b1;
      req_op              <= op;
      req_chance_draw     <= chance;
      req_gap_offset_draw <= offset;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = step_eyelid(op, chance, offset);
      lid_due_q.push_back(typed ? typed_want : want);
      @(negedge clock);
   endtask

   // stop offering and let every expected beat come back
   task automatic drain_lid_queue();
      req_valid <= 1'b0;
      while (lid_due_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      case (idx)
         CSR_BLINK_LENGTH:  cfg_blink    = data[MS_W-1:0];
         CSR_CLOSE_LENGTH:  cfg_close    = data[MS_W-1:0];
         CSR_MIN_OPENNESS:  cfg_min_open = data[OPEN_W-1:0];
         CSR_DOUBLE_CHANCE: cfg_chance   = data[CHANCE_W-1:0];
         CSR_DOUBLE_GAP:    cfg_dgap     = data[MS_W-1:0];
         CSR_GAP_MIN:       cfg_gmin     = data[MS_W-1:0];
         CSR_GAP_MAX:       cfg_gmax     = data[MS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input lid_setting_type s);
      write_csr(CSR_BLINK_LENGTH, s.blink);
      write_csr(CSR_CLOSE_LENGTH, s.close);
      write_csr(CSR_MIN_OPENNESS, s.min_open);
      write_csr(CSR_DOUBLE_CHANCE, s.chance);
      write_csr(CSR_DOUBLE_GAP, s.dgap);
      write_csr(CSR_GAP_MIN, s.gmin);
      write_csr(CSR_GAP_MAX, s.gmax);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      int                  row;
      int                  rep;
      int                  ph;
      int                  n;
      int                  pick;
      lid_setting_type     s;
      logic [OP_W-1:0]     op;
      logic [CHANCE_W-1:0] chance;
      logic [MS_W-1:0]     offset;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_op              = OP_TICK;
      req_chance_draw     = '0;
      req_gap_offset_draw = '0;
      csr_we              = 1'b0;
      csr_index           = CSR_BLINK_LENGTH;
      csr_wdata           = '0;

      // predictor out of reset
      cfg_blink    = BLINK_LENGTH_RST;
      cfg_close    = CLOSE_LENGTH_RST;
      cfg_min_open = MIN_OPENNESS_RST;
      cfg_chance   = DOUBLE_CHANCE_RST;
      cfg_dgap     = DOUBLE_GAP_RST;
      cfg_gmin     = GAP_MIN_RST;
      cfg_gmax     = GAP_MAX_RST;
      env_on       = 1'b0;
      phase        = 0;
      wait_ms      = 0;
      dbl_pending  = 1'b0;
      lid_open     = FULL_OPEN;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening
      for (row = 0; row < $size(opening_rows); row++) begin
         for (rep = 0; rep < opening_rows[row].reps; rep++) begin
            pace_sender();
            offer_beat(opening_rows[row].op, opening_rows[row].chance,
                       opening_rows[row].offset, opening_rows[row].typed,
                       opening_rows[row].want);
         end
      end
      drain_lid_queue();

      // randomized beats over fixed and random settings
      for (ph = 0; ph < $size(fixed_settings) + RANDOM_SETS; ph++) begin
         if (ph < $size(fixed_settings)) begin
            s = fixed_settings[ph];
         end else begin
            s.blink    = CSR_DAT_W'($urandom_range(0, 300));
            s.close    = CSR_DAT_W'($urandom_range(0, 320));
            s.min_open = ($urandom_range(0, 3) == 0) ? CSR_DAT_W'($urandom())
                                                    : CSR_DAT_W'($urandom_range(0, 30000));
            s.chance   = CSR_DAT_W'($urandom_range(0, 1023));
            s.dgap     = CSR_DAT_W'($urandom_range(0, 120));
            s.gmin     = CSR_DAT_W'($urandom_range(0, 120));
            s.gmax     = CSR_DAT_W'($urandom_range(0, 400));
            s.beats    = 120;
         end
         load_settings(s);

         // long response hold while requests keep coming
         if (ph == 0) hold_req = 1'b1;

         for (n = 0; n < s.beats; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)      op = OP_TICK;
            else if (pick < 88) op = OP_BEGIN;
            else if (pick < 95) op = OP_BLINK;
            else                op = OP_UNUSED;
            chance = CHANCE_W'($urandom_range(0, 1023));
            offset = ($urandom_range(0, 1) == 0) ? MS_W'($urandom_range(0, 65535))
                                                 : MS_W'($urandom_range(0, 400));
            pace_sender();
            offer_beat(op, chance, offset, 1'b0, '0);
         end
         drain_lid_queue();
      end

      if (fail_count == 0) begin
         $display("blink_envelope_timer verification clean");
      end else begin
         $display("blink_envelope_timer verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bet_pkg.sv
sv/bet_div.sv
sv/blink_envelope_timer.sv
bench/blink_envelope_timer_test.sv
